// ===== hdl/vpi_pkg.sv =====
// shared types and constants of the video port interface
// no dependencies; used by every module of the block but vpi_ram
package vpi_pkg;

  // default video memory depth, power of two from 1024 to 16384
  localparam int unsigned VRAM_DEPTH_DEFAULT = 16384;
  // palette depth, power of two; only the low five index bits leave the block
  localparam int unsigned PALETTE_DEPTH = 32;
  // access pointer width
  localparam int unsigned PTR_W = 14;
  // packed widths of the output item
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;

  // bus access kind carried by each input item
  typedef enum logic [1:0] {
    MODE_DATA_RD   = 2'd0,
    MODE_DATA_WR   = 2'd1,
    MODE_CTRL_WR   = 2'd2,
    MODE_STATUS_RD = 2'd3
  } mode_e;

  // access code from the second control byte
  typedef enum logic [1:0] {
    CODE_VRAM_RD = 2'd0,
    CODE_VRAM_WR = 2'd1,
    CODE_REG_WR  = 2'd2,
    CODE_CRAM_WR = 2'd3
  } code_e;

  // one result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       reg_write_valid;
    logic [3:0] reg_index;
    logic [7:0] reg_value;
    logic       cram_write_valid;
    logic [4:0] cram_index;
    logic [7:0] cram_value;
  } result_t;

endpackage

// ===== hdl/vpi_ram.sv =====
// generic single-port synchronous ram with registered read data
// no dependencies
module vpi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write and one read per cycle, both at addr_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/vpi_port_ctrl.sv =====
// port state machine: pointer, control byte latch, access code, prefetch buffer
// drives the video memory port and the post-reset clearing pass; uses vpi_pkg
module vpi_port_ctrl #(
  parameter int unsigned VRAM_DEPTH = vpi_pkg::VRAM_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [7:0]                    value_i,
  input  logic [7:0]                    status_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output vpi_pkg::result_t              res_o,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [$clog2(VRAM_DEPTH)-1:0] ram_addr_o,
  output logic [7:0]                    ram_wdata_o,
  input  logic [7:0]                    ram_rdata_i,
  output logic                          clearing_o
);

  localparam int unsigned AW = $clog2(VRAM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VRAM_DEPTH - 1);
  localparam logic [4:0] CRAM_MASK = 5'(vpi_pkg::PALETTE_DEPTH - 1);

  logic [vpi_pkg::PTR_W-1:0] ptr_q, ptr_d;
  logic [7:0]                fcb_q, fcb_d;
  vpi_pkg::code_e            code_q, code_d;
  logic                      pend_q, pend_d;
  logic [7:0]                prefetch_q, prefetch_d;
  logic                      load_q, load_d;
  logic                      clearing_q, clearing_d;
  logic [AW-1:0]             clr_addr_q, clr_addr_d;

  logic                      accept;
  logic [7:0]                buf_eff;
  logic [vpi_pkg::PTR_W-1:0] ptr_new;
  vpi_pkg::code_e            new_code;

  assign in_ready_o  = res_ready_i && !clearing_q;
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = accept;
  assign clearing_o  = clearing_q;

  // prefetch value, forwarded from the ram the cycle after a fetch
  assign buf_eff  = load_q ? ram_rdata_i : prefetch_q;
  assign ptr_new  = {value_i[5:0], fcb_q};
  assign new_code = vpi_pkg::code_e'(value_i[7:6]);

  // item decode, state update and memory request
  always_comb begin
    ptr_d       = ptr_q;
    fcb_d       = fcb_q;
    code_d      = code_q;
    pend_d      = pend_q;
    prefetch_d  = buf_eff;
    load_d      = 1'b0;
    clearing_d  = clearing_q;
    clr_addr_d  = clr_addr_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = ptr_q[AW-1:0];
    ram_wdata_o = value_i;
    res_o       = '0;

    if (clearing_q) begin
      // zero the video memory one entry a cycle
      ram_we_o    = 1'b1;
      ram_addr_o  = clr_addr_q;
      ram_wdata_o = 8'h00;
      clr_addr_d  = clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clearing_d = 1'b0;
      end
    end else if (accept) begin
      unique case (vpi_pkg::mode_e'(mode_i))
        vpi_pkg::MODE_DATA_RD: begin
          res_o.read_data = buf_eff;
          ram_re_o        = 1'b1;
          load_d          = 1'b1;
          ptr_d           = ptr_q + vpi_pkg::PTR_W'(1);
          pend_d          = 1'b0;
        end
        vpi_pkg::MODE_DATA_WR: begin
          pend_d = 1'b0;
          ptr_d  = ptr_q + vpi_pkg::PTR_W'(1);
          if (code_q == vpi_pkg::CODE_CRAM_WR) begin
            res_o.cram_write_valid = 1'b1;
            res_o.cram_index       = ptr_q[4:0] & CRAM_MASK;
            res_o.cram_value       = value_i;
          end else begin
            ram_we_o   = 1'b1;
            prefetch_d = value_i;
          end
        end
        vpi_pkg::MODE_CTRL_WR: begin
          if (pend_q) begin
            code_d = new_code;
            pend_d = 1'b0;
            if (new_code == vpi_pkg::CODE_REG_WR) begin
              res_o.reg_write_valid = 1'b1;
              res_o.reg_index       = value_i[3:0];
              res_o.reg_value       = fcb_q;
            end else if (new_code == vpi_pkg::CODE_VRAM_RD) begin
              ram_re_o   = 1'b1;
              ram_addr_o = ptr_new[AW-1:0];
              load_d     = 1'b1;
              ptr_d      = ptr_new + vpi_pkg::PTR_W'(1);
            end else begin
              ptr_d = ptr_new;
            end
          end else begin
            ptr_d  = {ptr_q[vpi_pkg::PTR_W-1:8], value_i};
            fcb_d  = value_i;
            pend_d = 1'b1;
          end
        end
        vpi_pkg::MODE_STATUS_RD: begin
          res_o.read_data = status_i;
          pend_d          = 1'b0;
        end
        default: begin
          pend_d = pend_q;
        end
      endcase
    end
  end

  // port state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      fcb_q      <= '0;
      code_q     <= vpi_pkg::CODE_VRAM_RD;
      pend_q     <= 1'b0;
      prefetch_q <= '0;
      load_q     <= 1'b0;
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      ptr_q      <= ptr_d;
      fcb_q      <= fcb_d;
      code_q     <= code_d;
      pend_q     <= pend_d;
      prefetch_q <= prefetch_d;
      load_q     <= load_d;
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

endmodule

// ===== hdl/vpi_out_skid.sv =====
// two-entry output stage: output register plus skid register
// input side ready depends only on registered state; uses vpi_pkg
module vpi_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vpi_pkg::result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vpi_pkg::result_t out_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  vpi_pkg::result_t out_q, out_d;
  vpi_pkg::result_t skid_q, skid_d;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // move items between input, skid and output register
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// ===== hdl/video_port_interface.sv =====
// top level of the video display processor host port
// instantiates vpi_port_ctrl, vpi_ram and vpi_out_skid; uses vpi_pkg

// One bus access is one item and yields one result item. The block takes an
// item every clock cycle unless the output stage is full or a clearing pass
// runs: each item makes at most one access to the single port of the video
// memory, and the prefetch byte fetched by a data read or a read-setup
// control write is forwarded from the memory read register to the next item.
// Results pass through a two-entry output stage, so input items keep flowing
// while one result waits to be taken. After reset a clearing pass zeroes all
// VRAM_DEPTH entries with s_axis_tready low. Palette writes are not stored
// here: each one leaves the block as a cram write in the result item.
module video_port_interface #(
  parameter int unsigned VRAM_DEPTH = vpi_pkg::VRAM_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // value [7:0], status_flags [15:8]
  input  logic [15:0] s_axis_tdata,
  // mode [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data [7:0], reg_index [11:8], reg_value [19:12], cram_index [24:20],
  // cram_value [32:25], zero [39:33]
  output logic [vpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // reg_write_valid [0], cram_write_valid [1]
  output logic [vpi_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int unsigned AW = $clog2(VRAM_DEPTH);

  logic             skid_ready;
  logic             res_valid;
  vpi_pkg::result_t res;
  vpi_pkg::result_t out_res;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic             clearing;

  vpi_port_ctrl #(
    .VRAM_DEPTH(VRAM_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .value_i    (s_axis_tdata[7:0]),
    .status_i   (s_axis_tdata[15:8]),
    .res_ready_i(skid_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata),
    .clearing_o (clearing)
  );

  vpi_ram #(
    .WIDTH(8),
    .DEPTH(VRAM_DEPTH)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  vpi_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .res_i      (res),
    .ready_o    (skid_ready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (out_res)
  );

  // pack the result item
  assign m_axis_tdata = {7'd0, out_res.cram_value, out_res.cram_index, out_res.reg_value,
                         out_res.reg_index, out_res.read_data};
  assign m_axis_tuser = {out_res.cram_write_valid, out_res.reg_write_valid};

  // no item enters while the video memory is being cleared
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  // an accepted item always leaves a result waiting
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a result never carries both a register write and a palette write
  a_one_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("register and palette write in one result");

endmodule

// ===== verif/tb_video_port_interface.sv =====
// self-checking testbench for the video display processor host port
// drives bus access items, predicts every result item and compares them
// depends on vpi_pkg and video_port_interface
module tb_video_port_interface;
  import vpi_pkg::*;

  // clearing pass of the video memory plus a slow run, taken several times over
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned N_RANDOM    = 1550;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned DRAIN_WAIT  = 20;

  // one bus access as queued for the driver
  typedef struct {
    mode_e      mode;
    logic [7:0] value;
    logic [7:0] status;
    bit         drain_first;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  access_t access_q[$];
  result_t result_q[$];
  access_t tx_cur;
  int unsigned tx_gap = 0;
  int unsigned rx_cnt = 0;
  bit rx_stall = 1'b0;
  bit quiet = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predicted port state
  logic [7:0]       vram_img [VRAM_DEPTH_DEFAULT];
  logic [7:0]       pal_img  [PALETTE_DEPTH];
  logic [PTR_W-1:0] vdp_ptr;
  logic [7:0]       vdp_latch_byte;
  code_e            vdp_code;
  bit               vdp_pending;
  logic [7:0]       vdp_prefetch;

  video_port_interface u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // next port state and result item for one accepted access
  function automatic result_t predict_access(input access_t it);
    result_t    res;
    logic [4:0] pidx;
    res = '0;
    case (it.mode)
      MODE_DATA_RD: begin
        vdp_pending = 1'b0;
        res.read_data = vdp_prefetch;
        vdp_prefetch = vram_img[vdp_ptr];
        vdp_ptr = vdp_ptr + 1'b1;
      end
      MODE_DATA_WR: begin
        vdp_pending = 1'b0;
        if (vdp_code == CODE_CRAM_WR) begin
          pidx = vdp_ptr[4:0];
          pal_img[pidx] = it.value;
          res.cram_write_valid = 1'b1;
          res.cram_index = pidx;
          res.cram_value = it.value;
        end else begin
          vdp_prefetch = it.value;
          vram_img[vdp_ptr] = it.value;
        end
        vdp_ptr = vdp_ptr + 1'b1;
      end
      MODE_CTRL_WR: begin
        if (vdp_pending) begin
          vdp_code = code_e'(it.value[7:6]);
          vdp_pending = 1'b0;
          if (vdp_code == CODE_REG_WR) begin
            res.reg_write_valid = 1'b1;
            res.reg_index = it.value[3:0];
            res.reg_value = vdp_latch_byte;
          end else begin
            vdp_ptr = {it.value[5:0], vdp_latch_byte};
            if (vdp_code == CODE_VRAM_RD) begin
              vdp_prefetch = vram_img[vdp_ptr];
              vdp_ptr = vdp_ptr + 1'b1;
            end
          end
        end else begin
          vdp_ptr = {vdp_ptr[13:8], it.value};
          vdp_latch_byte = it.value;
          vdp_pending = 1'b1;
        end
      end
      default: begin
        vdp_pending = 1'b0;
        res.read_data = it.status;
      end
    endcase
    return res;
  endfunction

  task automatic add_access(input mode_e m, input logic [7:0] v);
    access_t it;
    it.mode = m;
    it.value = v;
    it.status = 8'($urandom);
    it.drain_first = 1'b0;
    access_q.push_back(it);
  endtask

  task automatic add_ctrl_pair(input logic [7:0] first_b, input logic [7:0] second_b);
    add_access(MODE_CTRL_WR, first_b);
    add_access(MODE_CTRL_WR, second_b);
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    fail_cnt++;
  endtask

  // driver: presents queued items, predicts each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    bit accepted;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      quiet <= 1'b0;
    end else begin
      accepted = s_axis_tvalid && s_axis_tready;
      if (accepted) result_q.push_back(predict_access(tx_cur));
      quiet <= (access_q.size() < QUIET_TAIL);
      if (!s_axis_tvalid || accepted) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (access_q.size() != 0 &&
                     !(access_q[0].drain_first && result_q.size() != 0)) begin
          tx_cur = access_q.pop_front();
          s_axis_tdata <= {tx_cur.status, tx_cur.value};
          s_axis_tuser <= tx_cur.mode;
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls and comparison of each result item
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result item: expected none actual tdata %0h tuser %0h",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          if (m_axis_tdata[7:0] !== exp_r.read_data)
            report_field("read_data", 32'(exp_r.read_data), 32'(m_axis_tdata[7:0]));
          if (m_axis_tuser[0] !== exp_r.reg_write_valid)
            report_field("reg_write_valid", 32'(exp_r.reg_write_valid),
                         32'(m_axis_tuser[0]));
          if (m_axis_tdata[11:8] !== exp_r.reg_index)
            report_field("reg_index", 32'(exp_r.reg_index), 32'(m_axis_tdata[11:8]));
          if (m_axis_tdata[19:12] !== exp_r.reg_value)
            report_field("reg_value", 32'(exp_r.reg_value), 32'(m_axis_tdata[19:12]));
          if (m_axis_tuser[1] !== exp_r.cram_write_valid)
            report_field("cram_write_valid", 32'(exp_r.cram_write_valid),
                         32'(m_axis_tuser[1]));
          if (m_axis_tdata[24:20] !== exp_r.cram_index)
            report_field("cram_index", 32'(exp_r.cram_index), 32'(m_axis_tdata[24:20]));
          if (m_axis_tdata[32:25] !== exp_r.cram_value)
            report_field("cram_value", 32'(exp_r.cram_value), 32'(m_axis_tdata[32:25]));
          if (m_axis_tdata[39:33] !== 7'd0)
            report_field("pad", 32'd0, 32'(m_axis_tdata[39:33]));
        end
      end
      // ready and stall stretches
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (rx_cnt == 0) begin
        rx_stall = ($urandom_range(0, 9) < 3);
        rx_cnt = rx_stall ? $urandom_range(1, 15) : $urandom_range(1, 30);
        m_axis_tready <= !rx_stall;
      end else begin
        rx_cnt--;
        m_axis_tready <= !rx_stall;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned n_dir;
    int unsigned kind;
    int unsigned burst;
    int unsigned r;
    logic [5:0] hi;
    logic [7:0] lo;
    code_e code;
    logic [7:0] second_b;

    // predictor reset state
    foreach (vram_img[i]) vram_img[i] = 8'h00;
    foreach (pal_img[i]) pal_img[i] = 8'h00;
    vdp_ptr = '0;
    vdp_latch_byte = 8'h00;
    vdp_code = CODE_VRAM_RD;
    vdp_pending = 1'b0;
    vdp_prefetch = 8'h00;

    // directed: status extremes, empty read buffer
    add_access(MODE_STATUS_RD, 8'h00);
    access_q[$].status = 8'hFF;
    add_access(MODE_STATUS_RD, 8'hFF);
    access_q[$].status = 8'h00;
    add_access(MODE_DATA_RD, 8'h00);
    // write setup at zero, data writes of extreme bytes
    add_ctrl_pair(8'h00, {CODE_VRAM_WR, 6'h00});
    add_access(MODE_DATA_WR, 8'hFF);
    add_access(MODE_DATA_WR, 8'h00);
    // read setup prefetches, reads come back through the buffer
    add_ctrl_pair(8'h00, {CODE_VRAM_RD, 6'h00});
    add_access(MODE_DATA_RD, 8'h00);
    add_access(MODE_DATA_RD, 8'h00);
    // pointer wrap at the top of video memory
    add_ctrl_pair(8'hFF, {CODE_VRAM_WR, 6'h3F});
    add_access(MODE_DATA_WR, 8'h5A);
    add_access(MODE_DATA_WR, 8'hC3);
    add_ctrl_pair(8'hFF, {CODE_VRAM_RD, 6'h3F});
    add_access(MODE_DATA_RD, 8'h00);
    // register writes, highest and lowest index
    add_ctrl_pair(8'h9C, {CODE_REG_WR, 6'h0F});
    add_ctrl_pair(8'h00, {CODE_REG_WR, 6'h30});
    // palette writes across the last entry
    add_ctrl_pair(8'h1F, {CODE_CRAM_WR, 6'h00});
    add_access(MODE_DATA_WR, 8'hFF);
    add_access(MODE_DATA_WR, 8'h01);
    // status read and data write both cancel a half control pair
    add_access(MODE_CTRL_WR, 8'h12);
    add_access(MODE_STATUS_RD, 8'h00);
    add_access(MODE_CTRL_WR, 8'h34);
    add_access(MODE_DATA_WR, 8'hA5);
    n_dir = access_q.size();

    // random: half the draws are well-formed setup pairs followed by data bursts
    while (access_q.size() < n_dir + N_RANDOM) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        r = $urandom_range(0, 2);
        hi = (r == 0) ? 6'($urandom) : (r == 1 ? 6'h00 : 6'h3F);
        r = $urandom_range(0, 2);
        lo = (r == 0) ? 8'($urandom) :
             (r == 1 ? 8'($urandom_range(0, 31)) : 8'($urandom_range(224, 255)));
        r = $urandom_range(0, 9);
        code = (r < 4) ? CODE_VRAM_RD : (r < 7 ? CODE_VRAM_WR :
               (r < 8 ? CODE_REG_WR : CODE_CRAM_WR));
        second_b = {code, hi};
        add_ctrl_pair(lo, second_b);
        burst = $urandom_range(0, 8);
        repeat (burst) begin
          if ($urandom_range(0, 9) < ((code == CODE_VRAM_RD) ? 7 : 3))
            add_access(MODE_DATA_RD, 8'($urandom));
          else
            add_access(MODE_DATA_WR, 8'($urandom));
        end
      end else if (kind < 62) begin
        // half pair cut short by another access
        add_access(MODE_CTRL_WR, 8'($urandom));
        add_access(mode_e'($urandom_range(0, 1) ? $urandom_range(0, 1) : 3), 8'($urandom));
      end else if (kind < 72) begin
        add_access(MODE_STATUS_RD, 8'($urandom));
      end else begin
        add_access(mode_e'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    access_q[n_dir].drain_first = 1'b1;
    access_q[n_dir + N_RANDOM / 2].drain_first = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vpi_pkg.sv
hdl/vpi_ram.sv
hdl/vpi_port_ctrl.sv
hdl/vpi_out_skid.sv
hdl/video_port_interface.sv
verif/tb_video_port_interface.sv
